// ----- src/alnf_pkg.sv -----
// Package for the adaptive local noise filter: field widths, register
// indexes and reset values. No dependencies.
package alnf_pkg;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int NOISE_W    = 16;
    localparam int COORD_W    = 10;
    localparam int QUO_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE  = 2'd2;

    localparam logic [DIM_W-1:0]   RST_WIDTH  = 11'd512;
    localparam logic [DIM_W-1:0]   RST_HEIGHT = 11'd512;
    localparam logic [NOISE_W-1:0] RST_NOISE  = 16'd900;
    localparam logic [DIM_W-1:0]   MAX_ROWS   = 11'd1024;

endpackage

// ----- src/adaptive_local_noise_filter.sv -----
// Adaptive local noise filter over a (2R+1)x(2R+1) window, one item at a time.
// A border pixel goes from the column gather straight to the output load; an interior
// pixel passes the column gather, four multiply steps and the decision, then, if it
// needs a divide, the bit-serial divider with its done cycle, then the output load. The
// next item can be taken in the cycle after the result is registered; the serial column
// gather and the bit-serial divider set the pace. Sync active-low reset clears state.
module adaptive_local_noise_filter
    import alnf_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int WINDOW_RADIUS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_frame_start,
    // result output
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_W-1:0]    o_center_col,
    output logic [COORD_W-1:0]    o_center_row,
    output logic                  o_result_valid,
    output logic [PIX_W-1:0]      o_filtered,
    output logic                  o_clipped,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int LINES = 2 * WINDOW_RADIUS;
    localparam int WSIDE = LINES + 1;
    localparam int WAREA = WSIDE * WSIDE;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int KW    = $clog2(WSIDE);
    localparam int WW    = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int OXW   = (CW > COORD_W) ? CW : COORD_W;
    localparam int CSW   = $clog2(WSIDE * 255 + 1);
    localparam int CQW   = $clog2(WSIDE * 65025 + 1);
    localparam int SW    = $clog2(WAREA * 255 + 1);
    localparam int QW    = $clog2(WAREA * 65025 + 1);
    localparam int AW    = $clog2(WAREA + 1);
    localparam int DW    = QW + AW;
    localparam int TW    = SW + 1;
    localparam int VW    = NOISE_W + AW;
    localparam int P1W   = PIX_W + DW;
    localparam int P2W   = VW + TW + 1;
    localparam int NW    = ((P1W > P2W) ? P1W : P2W) + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_COL  = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_M4   = 4'd5;
    localparam logic [3:0] S_DEC  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // control
    logic [3:0]          r_state, n_state;
    logic [KW-1:0]       r_k;
    logic [CW-1:0]       r_col_cnt;
    logic [COORD_W-1:0]  r_row_cnt;
    logic [DIM_W-1:0]    r_cfg_w, r_cfg_h;
    logic [NOISE_W-1:0]  r_noise;
    logic                r_out_v;

    // payload
    logic [CW-1:0]       r_c;
    logic [COORD_W-1:0]  r_r;
    logic                r_win_ok;
    logic [PIX_W-1:0]    r_px, r_mid, r_g;
    logic [CSW-1:0]      r_cs;
    logic [CQW-1:0]      r_cq;
    logic [SW-1:0]       r_s;
    logic [QW-1:0]       r_q;
    logic [CSW-1:0]      r_col_s [WSIDE];
    logic [CQW-1:0]      r_col_q [WSIDE];
    logic [PIX_W-1:0]    r_col_m [WSIDE];
    logic [2*SW-1:0]     r_sq;
    logic signed [TW-1:0]  r_t;
    logic [VW-1:0]       r_n49;
    logic [DW-1:0]       r_d;
    logic signed [P2W-1:0] r_p2;
    logic [P1W-1:0]      r_p1;
    logic signed [NW-1:0]  r_num;
    logic [PIX_W-1:0]    r_fv;
    logic                r_clip;
    logic [COORD_W-1:0]  r_o_col, r_o_row;
    logic                r_o_rv, r_o_clip;
    logic [PIX_W-1:0]    r_o_fv;

    logic                in_acc, out_free, col_last;
    logic [CW-1:0]       cur_c;
    logic [COORD_W-1:0]  cur_r;
    logic [WW-1:0]       eff_w, c_inc;
    logic [DIM_W-1:0]    eff_h, r_inc;
    logic [PIX_W-1:0]    lb_pix, v;
    logic [CSW-1:0]      old_s;
    logic [CQW-1:0]      old_q;
    logic [2*PIX_W-1:0]  v_sq;
    logic [NW-1:0]       abs_num;
    logic                div_start, div_done;
    logic [QUO_W-1:0]    div_quo;
    logic [OXW-1:0]      ctr_col;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_out_v || i_ready;
    assign col_last    = (r_k == KW'(LINES));

    // raster position, with frame_start forcing the origin
    assign cur_c = i_frame_start ? '0 : r_col_cnt;
    assign cur_r = i_frame_start ? '0 : r_row_cnt;

    always_comb begin
        if (WW'(r_cfg_w) > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h > MAX_ROWS) begin
            eff_h = MAX_ROWS;
        end else if (r_cfg_h == '0) begin
            eff_h = DIM_W'(1);
        end else begin
            eff_h = r_cfg_h;
        end
    end

    assign c_inc = WW'(cur_c) + WW'(1);
    assign r_inc = DIM_W'(cur_r) + DIM_W'(1);

    alnf_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .LINES     (LINES)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rd      (in_acc),
        .i_rd_addr (cur_c),
        .i_step    (r_state == S_COL),
        .i_wr      ((r_state == S_COL) && col_last),
        .i_wr_addr (r_c),
        .i_px      (r_px),
        .o_pix     (lb_pix)
    );

    // one pixel of the new column per cycle, oldest row first, live pixel last
    assign v     = col_last ? r_px : lb_pix;
    assign v_sq  = v * v;
    assign old_s = col_last ? '0 : r_col_s[r_k + KW'(1)];
    assign old_q = col_last ? '0 : r_col_q[r_k + KW'(1)];

    assign abs_num   = NW'(-r_num);
    assign div_start = (r_state == S_DEC) && (r_d != '0) && !r_num[NW-1]
                       && (r_num < $signed(NW'(r_d) << QUO_W));

    alnf_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (NW'(r_num)),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_COL;
            S_COL:  if (col_last) n_state = r_win_ok ? S_M1 : S_FIN;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_DEC;
            S_DEC:  n_state = div_start ? S_DIV : S_FIN;
            S_DIV:  if (div_done) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_cfg_w   <= RST_WIDTH;
            r_cfg_h   <= RST_HEIGHT;
            r_noise   <= RST_NOISE;
            r_out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_w <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: r_cfg_h <= i_cfg_data[DIM_W-1:0];
                    CFG_NOISE:  r_noise <= i_cfg_data[NOISE_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_k <= '0;
                if (c_inc >= eff_w) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= (r_inc >= eff_h) ? '0 : r_inc[COORD_W-1:0];
                end else begin
                    r_col_cnt <= c_inc[CW-1:0];
                    r_row_cnt <= cur_r;
                end
            end else if (r_state == S_COL) begin
                r_k <= r_k + KW'(1);
            end
            if (r_state == S_FIN && out_free) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign ctr_col = OXW'(r_c) - OXW'(WINDOW_RADIUS);

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_c      <= cur_c;
                r_r      <= cur_r;
                r_px     <= i_pixel;
                r_win_ok <= (cur_c >= CW'(LINES)) && (cur_r >= COORD_W'(LINES));
                r_cs     <= '0;
                r_cq     <= '0;
                r_s      <= '0;
                r_q      <= '0;
            end
            S_COL: begin
                r_cs <= r_cs + CSW'(v);
                r_cq <= r_cq + CQW'(v_sq);
                r_s  <= r_s + SW'(v) + SW'(old_s);
                r_q  <= r_q + QW'(v_sq) + QW'(old_q);
                if (r_k == KW'(WINDOW_RADIUS)) r_mid <= v;
                if (col_last) begin
                    // window moves one column left
                    for (int j = 0; j < WSIDE - 1; j++) begin
                        r_col_s[j] <= r_col_s[j+1];
                        r_col_q[j] <= r_col_q[j+1];
                        r_col_m[j] <= r_col_m[j+1];
                    end
                    r_col_s[WSIDE-1] <= r_cs + CSW'(v);
                    r_col_q[WSIDE-1] <= r_cq + CQW'(v_sq);
                    r_col_m[WSIDE-1] <= r_mid;
                    r_fv   <= '0;
                    r_clip <= 1'b0;
                end
            end
            S_M1: begin
                r_g   <= r_col_m[WINDOW_RADIUS];
                r_sq  <= (2*SW)'(r_s) * (2*SW)'(r_s);
                r_t   <= $signed(TW'(WAREA) * TW'(r_col_m[WINDOW_RADIUS]))
                         - $signed(TW'(r_s));
                r_n49 <= VW'(r_noise) * VW'(WAREA);
            end
            S_M2: begin
                // D = N*Q - S*S is never negative
                r_d  <= DW'(WAREA) * DW'(r_q) - DW'(r_sq);
                r_p2 <= P2W'($signed({1'b0, r_n49})) * P2W'(r_t);
            end
            S_M3: r_p1 <= P1W'(r_g) * P1W'(r_d);
            S_M4: r_num <= $signed(NW'(r_p1)) - $signed(NW'(r_p2));
            S_DEC: begin
                if (r_d == '0) begin
                    r_fv   <= r_g;      // flat window passes through
                    r_clip <= 1'b0;
                end else if (r_num[NW-1]) begin
                    // truncation toward zero: small negatives give 0 unclipped
                    r_fv   <= '0;
                    r_clip <= (abs_num >= NW'(r_d));
                end else if (!div_start) begin
                    r_fv   <= '1;
                    r_clip <= 1'b1;
                end
            end
            S_DIV: if (div_done) r_fv <= div_quo;
            S_FIN: begin
                if (out_free) begin
                    r_o_rv   <= r_win_ok;
                    r_o_col  <= r_win_ok ? ctr_col[COORD_W-1:0] : '0;
                    r_o_row  <= r_win_ok ? r_r - COORD_W'(WINDOW_RADIUS) : '0;
                    r_o_fv   <= r_fv;
                    r_o_clip <= r_clip;
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_out_v;
    assign o_center_col   = r_o_col;
    assign o_center_row   = r_o_row;
    assign o_result_valid = r_o_rv;
    assign o_filtered     = r_o_fv;
    assign o_clipped      = r_o_clip;

endmodule

// ----- src/alnf_linebuf.sv -----
// Line store: one word per column holding the previous rows, oldest in the
// low byte, unloaded one pixel per cycle while stepped. Depends on alnf_pkg.
module alnf_linebuf
    import alnf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int LINES     = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rd,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_step,
    input  logic                         i_wr,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]             i_px,
    output logic [PIX_W-1:0]             o_pix
);
    localparam int WORD_W = PIX_W * LINES;

    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_shift;

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_word  <= r_mem[i_rd_addr];
            r_shift <= r_mem[i_rd_addr];
        end else if (i_step) begin
            r_shift <= r_shift >> PIX_W;
        end
        if (i_wr) begin
            // age every row by one, newest pixel on top
            r_mem[i_wr_addr] <= {i_px, r_word[WORD_W-1:PIX_W]};
        end
    end

    assign o_pix = r_shift[PIX_W-1:0];

endmodule

// ----- src/alnf_div.sv -----
// Restoring divider, one quotient bit per cycle, for a quotient known to be
// below 2**QUO_W. Depends on alnf_pkg.
module alnf_div
    import alnf_pkg::*;
#(
    parameter int NUM_W = 39,
    parameter int DEN_W = 28
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quo
);
    localparam int CNT_W = $clog2(QUO_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_quo;
    logic [NUM_W-1:0]  trial;
    logic              ge;

    assign trial = NUM_W'(r_den) << r_cnt;
    assign ge    = r_rem >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - trial;
            end
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- src/alnf_checker.sv -----
// Port-level checks for adaptive_local_noise_filter, attached by bind.
// Depends on alnf_pkg and the top level's ports.
module alnf_checker
    import alnf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [COORD_W-1:0] o_center_col,
    input logic [COORD_W-1:0] o_center_row,
    input logic               o_result_valid,
    input logic [PIX_W-1:0]   o_filtered,
    input logic               o_clipped
);
    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_filtered)
                                   && $stable(o_center_col)))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item taken while one is in work");

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_valid) |-> (o_filtered == '0 && !o_clipped
            && o_center_col == '0 && o_center_row == '0))
        else $error("border result carries data");

    a_clip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |-> (o_filtered == '0 || o_filtered == '1))
        else $error("clipped value not at a rail");

endmodule

bind adaptive_local_noise_filter alnf_checker u_alnf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_center_col   (o_center_col),
    .o_center_row   (o_center_row),
    .o_result_valid (o_result_valid),
    .o_filtered     (o_filtered),
    .o_clipped      (o_clipped)
);
